@@ hdl/lchs_pkg.sv @@
// ----------------------------------------------------------------------------
// LBA to CHS request packer: shared types and constants
// Field widths, register indexes and the fixed codes of the request words.
// ----------------------------------------------------------------------------
package lchs_pkg;

  localparam int unsigned LbaW     = 24;
  localparam int unsigned CountW   = 8;
  localparam int unsigned HeadsW   = 8;
  localparam int unsigned SptW     = 6;
  localparam int unsigned DriveW   = 8;
  localparam int unsigned CylW     = 10;
  localparam int unsigned SecW     = 6;
  localparam int unsigned WordW    = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [7:0]      ReadFunc = 8'h02;
  localparam logic [CylW-1:0] CylLimit = 10'd1023;

  localparam logic [HeadsW-1:0] HeadsMaxRst = 8'd15;
  localparam logic [SptW-1:0]   SptRst      = 6'd63;
  localparam logic [DriveW-1:0] DriveRst    = 8'd128;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEADS_MAX = 2'd0,
    REG_SPT       = 2'd1,
    REG_DRIVE     = 2'd2
  } cfg_reg_e;

endpackage

@@ hdl/lchs_req_if.sv @@
// ----------------------------------------------------------------------------
// LBA to CHS request packer: request channel
// Carries one address and sector count per item.
// ----------------------------------------------------------------------------
interface lchs_req_if
  import lchs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [LbaW-1:0]   lba;
  logic [CountW-1:0] sector_count;

  modport source (output valid, output lba, output sector_count, input ready);
  modport sink (input valid, input lba, input sector_count, output ready);
endinterface

@@ hdl/lchs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// LBA to CHS request packer: result channel
// Carries the geometry and the three packed request words per item.
// ----------------------------------------------------------------------------
interface lchs_rsp_if
  import lchs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CylW-1:0]   cylinder;
  logic [HeadsW-1:0] head;
  logic [SecW-1:0]   sector;
  logic [WordW-1:0]  function_word;
  logic [WordW-1:0]  cyl_sec_word;
  logic [WordW-1:0]  head_drive_word;
  logic              out_of_range;

  modport source (
    output valid, output cylinder, output head, output sector,
    output function_word, output cyl_sec_word, output head_drive_word,
    output out_of_range, input ready
  );
  modport sink (
    input valid, input cylinder, input head, input sector,
    input function_word, input cyl_sec_word, input head_drive_word,
    input out_of_range, output ready
  );
endinterface

@@ hdl/lchs_div_cell.sv @@
// ----------------------------------------------------------------------------
// LBA to CHS request packer: division cell
// One registered restoring division step; passes the item to the next cell.
// ----------------------------------------------------------------------------
module lchs_div_cell #(
  parameter int unsigned N  = 24,
  parameter int unsigned DW = 6,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [DW-1:0] divisor_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [N-1:0]  quo_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] rem_o,
  output logic [N-1:0]  quo_o,
  output logic [SW-1:0] side_o
);

  logic [DW:0]   trial;
  logic [DW+1:0] diff;
  logic          fits;
  logic [DW-1:0] rem_d;
  logic [N-1:0]  quo_d;
  logic          valid_q;
  logic [DW-1:0] rem_q;
  logic [N-1:0]  quo_q;
  logic [SW-1:0] side_q;

  assign trial = {rem_i, quo_i[N-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor_i};
  assign fits  = ~diff[DW+1];
  assign rem_d = fits ? diff[DW-1:0] : trial[DW-1:0];
  assign quo_d = {quo_i[N-2:0], fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

@@ hdl/lchs_div_chain.sv @@
// ----------------------------------------------------------------------------
// LBA to CHS request packer: division chain
// A row of N division cells, one quotient bit per cell, one item per cycle while en_i is high.
// ----------------------------------------------------------------------------
module lchs_div_chain #(
  parameter int unsigned N  = 24,
  parameter int unsigned DW = 6,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [DW-1:0] divisor_i,
  input  logic          valid_i,
  input  logic [N-1:0]  dividend_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] rem_o,
  output logic [N-1:0]  quo_o,
  output logic [SW-1:0] side_o
);

  logic [N:0]         valid_s;
  logic [N:0][DW-1:0] rem_s;
  logic [N:0][N-1:0]  quo_s;
  logic [N:0][SW-1:0] side_s;

  assign valid_s[0] = valid_i;
  assign rem_s[0]   = '0;
  assign quo_s[0]   = dividend_i;
  assign side_s[0]  = side_i;

  for (genvar g = 0; g < N; g++) begin : g_cell
    lchs_div_cell #(
      .N  (N),
      .DW (DW),
      .SW (SW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en_i),
      .divisor_i (divisor_i),
      .valid_i   (valid_s[g]),
      .rem_i     (rem_s[g]),
      .quo_i     (quo_s[g]),
      .side_i    (side_s[g]),
      .valid_o   (valid_s[g+1]),
      .rem_o     (rem_s[g+1]),
      .quo_o     (quo_s[g+1]),
      .side_o    (side_s[g+1])
    );
  end

  assign valid_o = valid_s[N];
  assign rem_o   = rem_s[N];
  assign quo_o   = quo_s[N];
  assign side_o  = side_s[N];

endmodule

@@ hdl/lba_to_chs_request_pack_top.sv @@
// ----------------------------------------------------------------------------
// LBA to CHS request packer: top level
// Converts an address to cylinder, head and sector and packs the request words.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle while the result channel does not
// stall, and it returns the results in order. Each item passes through two
// chains of one-bit restoring division cells and a final output register: the
// first chain divides the address by the sectors per track, the second divides
// the track by the number of heads, and the output register packs the words. When
// the result channel stalls, the whole pipeline holds. Configuration should be
// written only while no item is in flight.
module lba_to_chs_request_pack_top
  import lchs_pkg::*;
#(
  parameter int unsigned LBA_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  lchs_req_if.sink            req_i,
  lchs_rsp_if.source          rsp_o
);

  localparam int unsigned SideW2 = CountW + SptW;
  localparam int unsigned NHeadsW = HeadsW + 1;

  logic [HeadsW-1:0] heads_max_q;
  logic [SptW-1:0]   spt_q;
  logic [DriveW-1:0] drive_q;

  logic               en;
  logic [LBA_BITS-1:0] lba_ext;
  logic [NHeadsW-1:0] nheads;

  logic                v1;
  logic [SptW-1:0]     rem1;
  logic [LBA_BITS-1:0] quo1;
  logic [CountW-1:0]   side1;

  logic                v2;
  logic [NHeadsW-1:0]  rem2;
  logic [LBA_BITS-1:0] quo2;
  logic [SideW2-1:0]   side2;

  logic              spt_zero;
  logic              cyl_big;
  logic [CylW-1:0]   cyl_d;
  logic [HeadsW-1:0] head_d;
  logic [SecW-1:0]   sec_d;
  logic              oor_d;

  logic              out_valid_q;
  logic [CylW-1:0]   cyl_q;
  logic [HeadsW-1:0] head_q;
  logic [SecW-1:0]   sec_q;
  logic [CountW-1:0] count_q;
  logic              oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heads_max_q <= HeadsMaxRst;
      spt_q       <= SptRst;
      drive_q     <= DriveRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_HEADS_MAX: heads_max_q <= cfg_wdata_i[HeadsW-1:0];
        REG_SPT:       spt_q       <= cfg_wdata_i[SptW-1:0];
        REG_DRIVE:     drive_q     <= cfg_wdata_i[DriveW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign en          = ~out_valid_q | rsp_o.ready;
  assign req_i.ready = en;
  assign lba_ext     = LBA_BITS'(req_i.lba);
  assign nheads      = {1'b0, heads_max_q} + NHeadsW'(1);

  lchs_div_chain #(
    .N  (LBA_BITS),
    .DW (SptW),
    .SW (CountW)
  ) u_sec_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .divisor_i  (spt_q),
    .valid_i    (req_i.valid),
    .dividend_i (lba_ext),
    .side_i     (req_i.sector_count),
    .valid_o    (v1),
    .rem_o      (rem1),
    .quo_o      (quo1),
    .side_o     (side1)
  );

  lchs_div_chain #(
    .N  (LBA_BITS),
    .DW (NHeadsW),
    .SW (SideW2)
  ) u_head_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .divisor_i  (nheads),
    .valid_i    (v1),
    .dividend_i (quo1),
    .side_i     ({side1, rem1}),
    .valid_o    (v2),
    .rem_o      (rem2),
    .quo_o      (quo2),
    .side_o     (side2)
  );

  assign spt_zero = (spt_q == '0);
  assign cyl_big  = |quo2[LBA_BITS-1:CylW];

  always_comb begin
    cyl_d  = '0;
    head_d = '0;
    sec_d  = '0;
    oor_d  = 1'b1;
    if (!spt_zero) begin
      head_d = rem2[HeadsW-1:0];
      sec_d  = side2[SptW-1:0] + SecW'(1);
      oor_d  = cyl_big;
      cyl_d  = cyl_big ? CylLimit : quo2[CylW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cyl_q   <= cyl_d;
      head_q  <= head_d;
      sec_q   <= sec_d;
      count_q <= side2[SideW2-1:SptW];
      oor_q   <= oor_d;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.cylinder        = cyl_q;
  assign rsp_o.head            = head_q;
  assign rsp_o.sector          = sec_q;
  assign rsp_o.function_word   = {ReadFunc, count_q};
  assign rsp_o.cyl_sec_word    = {cyl_q[7:0], cyl_q[9:8], sec_q};
  assign rsp_o.head_drive_word = {head_q, drive_q};
  assign rsp_o.out_of_range    = oor_q;

endmodule

@@ hdl/lchs_checker.sv @@
// ----------------------------------------------------------------------------
// LBA to CHS request packer: port checker
// Watches the result channel of the top level and checks its hold, range and packing rules.
// ----------------------------------------------------------------------------
module lchs_checker
  import lchs_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [CylW-1:0]   cylinder_i,
  input logic [HeadsW-1:0] head_i,
  input logic [SecW-1:0]   sector_i,
  input logic [WordW-1:0]  function_word_i,
  input logic [WordW-1:0]  cyl_sec_word_i,
  input logic [WordW-1:0]  head_drive_word_i,
  input logic              out_of_range_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cyl_sec_word_i)
      && $stable(head_drive_word_i) && $stable(function_word_i))
    else $error("Stalled result item changed.");

  a_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && sector_i == '0 |-> out_of_range_i && cylinder_i == '0)
    else $error("Zero sector without the out-of-range case.");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_of_range_i && sector_i != '0 |-> cylinder_i == CylLimit)
    else $error("Out-of-range cylinder not saturated.");

  a_pack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cyl_sec_word_i[5:0] == sector_i
      && cyl_sec_word_i[15:8] == cylinder_i[7:0]
      && cyl_sec_word_i[7:6] == cylinder_i[9:8]
      && head_drive_word_i[15:8] == head_i
      && function_word_i[15:8] == ReadFunc)
    else $error("Request words do not match the fields.");

endmodule

bind lba_to_chs_request_pack_top lchs_checker u_lchs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (rsp_o.valid),
  .out_ready_i       (rsp_o.ready),
  .cylinder_i        (rsp_o.cylinder),
  .head_i            (rsp_o.head),
  .sector_i          (rsp_o.sector),
  .function_word_i   (rsp_o.function_word),
  .cyl_sec_word_i    (rsp_o.cyl_sec_word),
  .head_drive_word_i (rsp_o.head_drive_word),
  .out_of_range_i    (rsp_o.out_of_range)
);
